### rtl/u8dec_pkg.sv
package u8dec_pkg;

    localparam int unsigned CP_W = 32;

    // Highest trailing-byte count a lead byte can announce
    localparam logic [2:0] MAX_TRAIL = 3'd5;

    localparam logic [CP_W-1:0] OFS_TRAIL1 = 32'h0000_3080;
    localparam logic [CP_W-1:0] OFS_TRAIL2 = 32'h000E_2080;
    localparam logic [CP_W-1:0] OFS_TRAIL3 = 32'h03C8_2080;
    localparam logic [CP_W-1:0] OFS_TRAIL4 = 32'hFA08_2080;
    localparam logic [CP_W-1:0] OFS_TRAIL5 = 32'h8208_2080;

    localparam logic [CP_W-1:0] CP_RSQUO_IN  = 32'd146;
    localparam logic [CP_W-1:0] CP_LDQUO_IN  = 32'd147;
    localparam logic [CP_W-1:0] CP_RDQUO_IN  = 32'd148;
    localparam logic [CP_W-1:0] CP_MDASH_IN  = 32'd151;
    localparam logic [CP_W-1:0] CP_RSQUO_OUT = 32'h0000_2019;
    localparam logic [CP_W-1:0] CP_LDQUO_OUT = 32'h0000_201C;
    localparam logic [CP_W-1:0] CP_RDQUO_OUT = 32'h0000_201D;
    localparam logic [CP_W-1:0] CP_MDASH_OUT = 32'h0000_2014;

    typedef struct packed {
        logic [2:0]      remaining;
        logic [2:0]      len_idx;
        logic [CP_W-1:0] acc;
    } t_dec_state;

    typedef struct packed {
        logic            valid;
        logic [CP_W-1:0] code_point;
        logic            final_char;
        logic            truncated;
    } t_dec_result;

    function automatic logic [2:0] trail_count(input logic [7:0] b);
        logic [2:0] n;
        priority if (b < 8'hC0) n = 3'd0;
        else if (b < 8'hE0)     n = 3'd1;
        else if (b < 8'hF0)     n = 3'd2;
        else if (b < 8'hF8)     n = 3'd3;
        else if (b < 8'hFC)     n = 3'd4;
        else                    n = 3'd5;
        return n;
    endfunction

    function automatic logic [CP_W-1:0] seq_offset(input logic [2:0] idx);
        logic [CP_W-1:0] ofs;
        unique case (idx)
            3'd0:    ofs = '0;
            3'd1:    ofs = OFS_TRAIL1;
            3'd2:    ofs = OFS_TRAIL2;
            3'd3:    ofs = OFS_TRAIL3;
            3'd4:    ofs = OFS_TRAIL4;
            default: ofs = OFS_TRAIL5;
        endcase
        return ofs;
    endfunction

    function automatic logic [CP_W-1:0] punct_fixup(input logic [CP_W-1:0] v);
        logic [CP_W-1:0] r;
        priority if (v == CP_RSQUO_IN) r = CP_RSQUO_OUT;
        else if (v == CP_LDQUO_IN)     r = CP_LDQUO_OUT;
        else if (v == CP_RDQUO_IN)     r = CP_RDQUO_OUT;
        else if (v == CP_MDASH_IN)     r = CP_MDASH_OUT;
        else                           r = v;
        return r;
    endfunction

endpackage

### rtl/u8dec_in_if.sv
interface u8dec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_string;

    modport source (output valid, output data_byte, output end_of_string, input ready);
    modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

### rtl/u8dec_out_if.sv
interface u8dec_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] code_point;
    logic        final_char;
    logic        truncated;

    modport source (output valid, output code_point, output final_char, output truncated,
                    input ready);
    modport sink   (input valid, input code_point, input final_char, input truncated,
                    output ready);
endinterface

### rtl/utf8_to_utf32_decoder.sv
// Path: the last byte of a code point is taken into the input register, then the code point
// goes into the result register; a result held by the sink can hold it between the two.
// Throughput: one byte per cycle; the decode step is a single shift-add, subtract and
// compare between the two registers. A result held by the sink stalls the input.
// Reset: synchronous, active low; clears sequence state and both valid flags.
module utf8_to_utf32_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    u8dec_in_if.sink           i_in,
    u8dec_out_if.source        o_out
);

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_eos;
    u8dec_pkg::t_dec_state  r_state;
    u8dec_pkg::t_dec_state  n_state;
    u8dec_pkg::t_dec_result n_result;
    u8dec_pkg::t_dec_result r_out;
    logic                   out_free;
    logic                   step_go;

    assign out_free   = !r_out.valid || o_out.ready;
    assign step_go    = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;

    u8dec_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_eos    (r_in_eos),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.data_byte;
            r_in_eos  <= i_in.end_of_string;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out.valid <= 1'b0;
        end else begin
            if (step_go) begin
                r_state <= n_state;
            end
            // Advance the result register whenever it is free
            if (out_free) begin
                r_out.valid <= step_go && n_result.valid;
            end
        end
        if (step_go && n_result.valid) begin
            r_out.code_point <= n_result.code_point;
            r_out.final_char <= n_result.final_char;
            r_out.truncated  <= n_result.truncated;
        end
    end

    assign o_out.valid      = r_out.valid;
    assign o_out.code_point = r_out.code_point;
    assign o_out.final_char = r_out.final_char;
    assign o_out.truncated  = r_out.truncated;

endmodule

### rtl/u8dec_step.sv
module u8dec_step (
    input  u8dec_pkg::t_dec_state  i_state,
    input  logic [7:0]             i_byte,
    input  logic                   i_eos,
    output u8dec_pkg::t_dec_state  o_state,
    output u8dec_pkg::t_dec_result o_result
);

    u8dec_pkg::t_dec_state mid;
    logic [2:0]            idx;
    logic [31:0]           value;

    always_comb begin
        // Gather: with no sequence open a byte starts one, inside a sequence any byte shifts in
        if (i_state.remaining == 3'd0) begin
            mid.remaining = u8dec_pkg::trail_count(i_byte);
            mid.len_idx   = u8dec_pkg::trail_count(i_byte);
            mid.acc       = {24'd0, i_byte};
        end else begin
            mid.remaining = i_state.remaining - 3'd1;
            mid.len_idx   = i_state.len_idx;
            mid.acc       = {i_state.acc[25:0], 6'd0} + {24'd0, i_byte};
        end

        idx   = (mid.len_idx > u8dec_pkg::MAX_TRAIL) ? u8dec_pkg::MAX_TRAIL : mid.len_idx;
        value = mid.acc - u8dec_pkg::seq_offset(idx);

        o_state  = mid;
        o_result = '0;
        if (mid.remaining == 3'd0) begin
            o_result.valid      = 1'b1;
            o_result.code_point = u8dec_pkg::punct_fixup(value);
            o_result.final_char = i_eos;
            o_state             = '0;
        end else if (i_eos) begin
            // String ended mid-sequence: drop the partial word, flag it
            o_result.valid      = 1'b1;
            o_result.final_char = 1'b1;
            o_result.truncated  = 1'b1;
            o_state             = '0;
        end
    end

endmodule

### dv/u8dec_cp_checker.sv
`timescale 1ns / 100ps

module u8dec_cp_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [7:0]                 i_in_byte,
    input  logic                       i_in_eos,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [u8dec_pkg::CP_W-1:0] i_out_cp,
    input  logic                       i_out_final,
    input  logic                       i_out_trunc,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_cp_count,
    output int                         o_trunc_count
);

    typedef struct packed {
        logic [u8dec_pkg::CP_W-1:0] code_point;
        logic                       final_char;
        logic                       truncated;
    } t_cp_word;

    t_cp_word                   cp_expect_q[$];

    logic [2:0]                 trail_left;
    logic [2:0]                 seq_len;
    logic [u8dec_pkg::CP_W-1:0] cp_acc;

    function automatic logic [2:0] lead_trail_len(input logic [7:0] b);
        if (b >= 8'hFC) return 3'd5;
        if (b >= 8'hF8) return 3'd4;
        if (b >= 8'hF0) return 3'd3;
        if (b >= 8'hE0) return 3'd2;
        if (b >= 8'hC0) return 3'd1;
        return 3'd0;
    endfunction

    function automatic logic [u8dec_pkg::CP_W-1:0] len_offset(input logic [2:0] n);
        case (n)
            3'd0:    return '0;
            3'd1:    return u8dec_pkg::OFS_TRAIL1;
            3'd2:    return u8dec_pkg::OFS_TRAIL2;
            3'd3:    return u8dec_pkg::OFS_TRAIL3;
            3'd4:    return u8dec_pkg::OFS_TRAIL4;
            default: return u8dec_pkg::OFS_TRAIL5;
        endcase
    endfunction

    function automatic logic [u8dec_pkg::CP_W-1:0] smart_punct(
        input logic [u8dec_pkg::CP_W-1:0] v
    );
        case (v)
            u8dec_pkg::CP_RSQUO_IN: return u8dec_pkg::CP_RSQUO_OUT;
            u8dec_pkg::CP_LDQUO_IN: return u8dec_pkg::CP_LDQUO_OUT;
            u8dec_pkg::CP_RDQUO_IN: return u8dec_pkg::CP_RDQUO_OUT;
            u8dec_pkg::CP_MDASH_IN: return u8dec_pkg::CP_MDASH_OUT;
            default:                return v;
        endcase
    endfunction

    // Advance the decode state by one byte; queue the code point it completes, or a truncated word
    task automatic decode_byte(input logic [7:0] b, input logic eos);
        t_cp_word w;
        if (trail_left == 3'd0) begin
            seq_len    = lead_trail_len(b);
            trail_left = seq_len;
            cp_acc     = {24'd0, b};
        end else begin
            cp_acc     = (cp_acc << 6) + {24'd0, b};
            trail_left = trail_left - 3'd1;
        end
        if (trail_left == 3'd0) begin
            w.code_point = smart_punct(cp_acc - len_offset(seq_len));
            w.final_char = eos;
            w.truncated  = 1'b0;
            cp_expect_q  = {cp_expect_q, w};
            cp_acc  = '0;
            seq_len = 3'd0;
        end else if (eos) begin
            // string ended mid-sequence: drop the partial sequence
            w.code_point = '0;
            w.final_char = 1'b1;
            w.truncated  = 1'b1;
            cp_expect_q  = {cp_expect_q, w};
            trail_left = 3'd0;
            seq_len    = 3'd0;
            cp_acc     = '0;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_cp_word exp_w;
        if (!i_rst_n) begin
            trail_left = 3'd0;
            seq_len    = 3'd0;
            cp_acc     = '0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_cp_count++;
                if (i_out_trunc) o_trunc_count++;
                if (cp_expect_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: unexpected code point cp=%h final=%b trunc=%b",
                                 $realtime, i_out_cp, i_out_final, i_out_trunc);
                end else begin
                    exp_w = cp_expect_q.pop_front();
                    if (exp_w.code_point !== i_out_cp || exp_w.final_char !== i_out_final ||
                        exp_w.truncated !== i_out_trunc) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: mismatch exp cp=%h final=%b trunc=%b, %s%h %s%b %s%b",
                                     $realtime, exp_w.code_point, exp_w.final_char,
                                     exp_w.truncated, "got cp=", i_out_cp, "final=",
                                     i_out_final, "trunc=", i_out_trunc);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                decode_byte(i_in_byte, i_in_eos);
        end
        o_pending = cp_expect_q.size();
    end

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        o_cp_count    = 0;
        o_trunc_count = 0;
    end

endmodule

### dv/tb_utf8_to_utf32_decoder.sv
`timescale 1ns / 100ps

module tb_utf8_to_utf32_decoder;

    logic i_clk;
    logic i_rst_n;

    u8dec_in_if  in_ch ();
    u8dec_out_if out_ch ();

    int fail_count;
    int pending;
    int cp_count;
    int trunc_count;

    int send_idle_pct;
    int recv_idle_pct;
    int bytes_sent;
    int strings_sent;

    // short directed strings; bit 8 marks the last byte of a string
    localparam logic [8:0] DIRECTED_SEQ [25] = '{
        9'h100,
        9'h07F, 9'h080, 9'h092, 9'h094, 9'h097, 9'h1BF,
        9'h0C2, 9'h192,
        9'h0E0, 9'h082, 9'h193,
        9'h0F0, 9'h080, 9'h082, 9'h194,
        9'h0FC, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF, 9'h1BF,
        9'h0F8, 9'h188,
        9'h1FF
    };

    utf8_to_utf32_decoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    u8dec_cp_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_ch.valid),
        .i_in_ready    (in_ch.ready),
        .i_in_byte     (in_ch.data_byte),
        .i_in_eos      (in_ch.end_of_string),
        .i_out_valid   (out_ch.valid),
        .i_out_ready   (out_ch.ready),
        .i_out_cp      (out_ch.code_point),
        .i_out_final   (out_ch.final_char),
        .i_out_trunc   (out_ch.truncated),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_cp_count    (cp_count),
        .o_trunc_count (trunc_count)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Call at a falling edge; returns at the falling edge after the word is taken
    task automatic push_byte(input logic [7:0] b, input logic eos);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.data_byte     <= b;
        in_ch.end_of_string <= eos;
        do @(posedge i_clk); while (!in_ch.ready);
        bytes_sent++;
        if (eos) strings_sent++;
        @(negedge i_clk);
    endtask

    // Hold the sender until every expected code point is out, then let the pipe settle
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [7:0] lead_byte(input int n);
        case (n)
            1:       return 8'(8'hC0 + $urandom_range(31));
            2:       return 8'(8'hE0 + $urandom_range(15));
            3:       return 8'(8'hF0 + $urandom_range(7));
            4:       return 8'(8'hF8 + $urandom_range(3));
            default: return 8'(8'hFC + $urandom_range(3));
        endcase
    endfunction

    function automatic logic [7:0] trail_byte();
        if ($urandom_range(19) == 0) return 8'($urandom_range(255));
        return 8'(8'h80 | $urandom_range(63));
    endfunction

    task automatic send_random_string();
        logic [7:0] str_q[$];
        int         n_chars;
        int         kind;
        int         n_trail;
        n_chars = $urandom_range(1, 10);
        for (int c = 0; c < n_chars; c++) begin
            kind = $urandom_range(99);
            if (kind < 30) begin
                str_q = {str_q, 8'($urandom_range(127))};
            end else if (kind < 40) begin
                // lone continuation bytes, often the ones that get punctuation fixup
                case ($urandom_range(5))
                    0:       str_q = {str_q, 8'h92};
                    1:       str_q = {str_q, 8'h93};
                    2:       str_q = {str_q, 8'h94};
                    3:       str_q = {str_q, 8'h97};
                    default: str_q = {str_q, 8'(8'h80 + $urandom_range(63))};
                endcase
            end else if (kind < 92) begin
                n_trail = (kind < 58) ? 1 : (kind < 72) ? 2 : (kind < 82) ? 3 :
                          (kind < 87) ? 4 : 5;
                str_q = {str_q, lead_byte(n_trail)};
                for (int t = 0; t < n_trail; t++) str_q = {str_q, trail_byte()};
            end else begin
                str_q = {str_q, 8'($urandom_range(255))};
            end
        end
        if ($urandom_range(99) < 12) begin
            // leave the string inside a multi-byte sequence
            n_trail = $urandom_range(1, 5);
            str_q = {str_q, lead_byte(n_trail)};
            for (int t = $urandom_range(n_trail - 1); t > 0; t--)
                str_q = {str_q, trail_byte()};
        end
        for (int i = 0; i < str_q.size(); i++)
            push_byte(str_q[i], i == str_q.size() - 1);
    endtask

    initial begin
        i_rst_n                = 1'b0;
        in_ch.valid            = 1'b0;
        in_ch.data_byte        = 8'h00;
        in_ch.end_of_string    = 1'b0;
        send_idle_pct          = 19;
        recv_idle_pct          = 46;
        bytes_sent             = 0;
        strings_sent           = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIRECTED_SEQ[i])
            push_byte(DIRECTED_SEQ[i][7:0], DIRECTED_SEQ[i][8]);
        while (bytes_sent < 90) send_random_string();
        wait_drained();
        while (bytes_sent < 175) send_random_string();
        wait_drained();

        send_idle_pct = 46;
        recv_idle_pct = 19;
        while (bytes_sent < 325) send_random_string();
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (bytes_sent < 440) send_random_string();
        wait_drained();
        repeat (10) @(negedge i_clk);

        $display("Sent %0d bytes in %0d strings under three idle patterns.",
                 bytes_sent, strings_sent);
        $display("Checked %0d code points, %0d of them from truncated strings.",
                 cp_count, trunc_count);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

### utf8_to_utf32_decoder.f
rtl/u8dec_pkg.sv
rtl/u8dec_in_if.sv
rtl/u8dec_out_if.sv
rtl/u8dec_step.sv
rtl/utf8_to_utf32_decoder.sv
dv/u8dec_cp_checker.sv
dv/tb_utf8_to_utf32_decoder.sv
